// ===== hdl/tcsa_pkg.sv =====
package tcsa_pkg;

    // Array geometry
    localparam int OUT_DIM   = 64;
    localparam int KERNEL_H  = 3;
    localparam int KERNEL_W  = 3;

    localparam int ACC_DEPTH = OUT_DIM * OUT_DIM;
    localparam int ADDR_W    = $clog2(ACC_DEPTH);
    localparam int W_DEPTH   = KERNEL_H * KERNEL_W;
    localparam int WIDX_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int KH_W      = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
    localparam int KW_W      = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;

    // Field widths
    localparam int OP_W      = 2;
    localparam int VAL_W     = 16;
    localparam int COORD_W   = 6;
    localparam int ACC_W     = 40;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SIZE_W    = 7;
    localparam int STEP_W    = 4;
    localparam int PAD_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    // Signed output position: row * stride - pad + tap * dilation
    localparam int POS_W     = 12;

    // Largest output size in use (register is 7 bits wide)
    localparam int SIZE_MAX  = (OUT_DIM < 127) ? OUT_DIM : 127;

    // Q8.8 to Q24.16 (accumulator scale)
    localparam int FRAC_SH   = 8;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_SCATTER = 2'd2,
        OP_READ    = 2'd3
    } tcsa_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_HEIGHT    = 3'd0,
        CFG_OUT_WIDTH     = 3'd1,
        CFG_STRIDE_ROWS   = 3'd2,
        CFG_STRIDE_COLS   = 3'd3,
        CFG_DILATION_ROWS = 3'd4,
        CFG_DILATION_COLS = 3'd5,
        CFG_PAD_TOP       = 3'd6,
        CFG_PAD_LEFT      = 3'd7
    } tcsa_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAT,
        ST_DRAIN,
        ST_RD_MEM,
        ST_RD_OUT
    } tcsa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic              load;       // capture word fields, set up tap positions
        logic              wt_wr;      // weight load word accepted
        logic              tap_en;     // issue one kernel tap
        logic              tap_wrap;   // this tap ends a kernel row
        logic [WIDX_W-1:0] widx;       // weight of this tap
        logic              clr_en;     // write bias at clr_addr
        logic [ADDR_W-1:0] clr_addr;
        logic              rd_en;      // read accumulator of captured row/col
        logic              out_load;   // move read data into output register
    } tcsa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
    } tcsa_status_t;

endpackage

// ===== hdl/tcsa_ctrl.sv =====
module tcsa_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic [tcsa_pkg::OP_W-1:0] op_in,
    output logic                   s_tready,
    input  tcsa_pkg::tcsa_status_t status,
    output tcsa_pkg::tcsa_cmd_t    cmd
);

    tcsa_pkg::tcsa_state_t state_reg, state_next;

    logic [tcsa_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [tcsa_pkg::KH_W-1:0]   kh_reg, kh_next;
    logic [tcsa_pkg::KW_W-1:0]   kw_reg, kw_next;
    logic [tcsa_pkg::WIDX_W-1:0] widx_reg, widx_next;

    logic accept;
    logic clr_last;
    logic col_last;
    logic tap_last;
    tcsa_pkg::tcsa_op_t op;

    assign op       = tcsa_pkg::tcsa_op_t'(op_in);
    assign s_tready = (state_reg == tcsa_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign clr_last = (clr_cnt_reg == tcsa_pkg::ADDR_W'(tcsa_pkg::ACC_DEPTH - 1));
    assign col_last = (kw_reg == tcsa_pkg::KW_W'(tcsa_pkg::KERNEL_W - 1));
    assign tap_last = col_last && (kh_reg == tcsa_pkg::KH_W'(tcsa_pkg::KERNEL_H - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcsa_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        tcsa_pkg::OP_CLEAR:   state_next = tcsa_pkg::ST_CLEAR;
                        tcsa_pkg::OP_LOAD:    state_next = tcsa_pkg::ST_IDLE;
                        tcsa_pkg::OP_SCATTER: state_next = tcsa_pkg::ST_SCAT;
                        tcsa_pkg::OP_READ:    state_next = tcsa_pkg::ST_RD_MEM;
                        default:              state_next = tcsa_pkg::ST_IDLE;
                    endcase
                end
            end
            tcsa_pkg::ST_CLEAR: begin
                if (clr_last) state_next = tcsa_pkg::ST_IDLE;
            end
            tcsa_pkg::ST_SCAT: begin
                if (tap_last) state_next = tcsa_pkg::ST_DRAIN;
            end
            tcsa_pkg::ST_DRAIN:  state_next = tcsa_pkg::ST_IDLE;
            tcsa_pkg::ST_RD_MEM: state_next = tcsa_pkg::ST_RD_OUT;
            tcsa_pkg::ST_RD_OUT: begin
                if (status.out_free) state_next = tcsa_pkg::ST_IDLE;
            end
            default: state_next = tcsa_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        cmd.widx     = widx_reg;
        cmd.clr_addr = clr_cnt_reg;
        cmd.tap_wrap = col_last;
        unique case (state_reg)
            tcsa_pkg::ST_IDLE: begin
                cmd.load  = accept;
                cmd.wt_wr = accept && (op == tcsa_pkg::OP_LOAD);
            end
            tcsa_pkg::ST_CLEAR:  cmd.clr_en   = 1'b1;
            tcsa_pkg::ST_SCAT:   cmd.tap_en   = 1'b1;
            tcsa_pkg::ST_DRAIN:  cmd.tap_en   = 1'b0;
            tcsa_pkg::ST_RD_MEM: cmd.rd_en    = 1'b1;
            tcsa_pkg::ST_RD_OUT: cmd.out_load = status.out_free;
            default:             cmd.tap_en   = 1'b0;
        endcase
    end

    // Sweep and tap counters
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        kh_next      = kh_reg;
        kw_next      = kw_reg;
        widx_next    = widx_reg;
        if (accept) begin
            clr_cnt_next = '0;
            kh_next      = '0;
            kw_next      = '0;
            widx_next    = '0;
        end else if (state_reg == tcsa_pkg::ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end else if (state_reg == tcsa_pkg::ST_SCAT) begin
            widx_next = widx_reg + 1'b1;
            if (col_last) begin
                kw_next = '0;
                kh_next = kh_reg + 1'b1;
            end else begin
                kw_next = kw_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcsa_pkg::ST_IDLE;
            clr_cnt_reg <= '0;
            kh_reg      <= '0;
            kw_reg      <= '0;
            widx_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            kh_reg      <= kh_next;
            kw_reg      <= kw_next;
            widx_reg    <= widx_next;
        end
    end

`ifndef SYNTHESIS
    // a scatter always runs the full kernel, then drains once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcsa_pkg::ST_SCAT && tap_last) |=> (state_reg == tcsa_pkg::ST_DRAIN))
        else $error("scatter did not drain after last tap");

    // clear sweep ends exactly at the last entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcsa_pkg::ST_CLEAR && !clr_last) |=> (state_reg == tcsa_pkg::ST_CLEAR))
        else $error("clear sweep left early");

    // tap column counter is back at zero by the time the engine drains
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcsa_pkg::ST_DRAIN) |-> (kw_reg == '0))
        else $error("tap column counter not wrapped at drain");
`endif

endmodule

// ===== hdl/tcsa_dp.sv =====
module tcsa_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [tcsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcsa_pkg::CFG_DAT_W-1:0]      cfg_data,
    // input word fields
    input  logic signed [tcsa_pkg::VAL_W-1:0]   in_value,
    input  logic [tcsa_pkg::COORD_W-1:0]        in_row,
    input  logic [tcsa_pkg::COORD_W-1:0]        in_col,
    // result side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [tcsa_pkg::ACC_W-1:0]   out_value,
    // control
    input  tcsa_pkg::tcsa_cmd_t                 cmd,
    output tcsa_pkg::tcsa_status_t              status
);

    // Configuration registers
    logic [tcsa_pkg::SIZE_W-1:0] out_height_reg, out_width_reg;
    logic [tcsa_pkg::STEP_W-1:0] stride_rows_reg, stride_cols_reg;
    logic [tcsa_pkg::STEP_W-1:0] dilation_rows_reg, dilation_cols_reg;
    logic [tcsa_pkg::PAD_W-1:0]  pad_top_reg, pad_left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_height_reg    <= tcsa_pkg::SIZE_W'(64);
            out_width_reg     <= tcsa_pkg::SIZE_W'(64);
            stride_rows_reg   <= tcsa_pkg::STEP_W'(1);
            stride_cols_reg   <= tcsa_pkg::STEP_W'(1);
            dilation_rows_reg <= tcsa_pkg::STEP_W'(1);
            dilation_cols_reg <= tcsa_pkg::STEP_W'(1);
            pad_top_reg       <= '0;
            pad_left_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (tcsa_pkg::tcsa_cfg_idx_t'(cfg_index))
                tcsa_pkg::CFG_OUT_HEIGHT:    out_height_reg    <= cfg_data;
                tcsa_pkg::CFG_OUT_WIDTH:     out_width_reg     <= cfg_data;
                tcsa_pkg::CFG_STRIDE_ROWS:   stride_rows_reg   <= cfg_data[tcsa_pkg::STEP_W-1:0];
                tcsa_pkg::CFG_STRIDE_COLS:   stride_cols_reg   <= cfg_data[tcsa_pkg::STEP_W-1:0];
                tcsa_pkg::CFG_DILATION_ROWS: dilation_rows_reg <= cfg_data[tcsa_pkg::STEP_W-1:0];
                tcsa_pkg::CFG_DILATION_COLS: dilation_cols_reg <= cfg_data[tcsa_pkg::STEP_W-1:0];
                tcsa_pkg::CFG_PAD_TOP:       pad_top_reg       <= cfg_data[tcsa_pkg::PAD_W-1:0];
                tcsa_pkg::CFG_PAD_LEFT:      pad_left_reg      <= cfg_data[tcsa_pkg::PAD_W-1:0];
                default:                     pad_left_reg      <= pad_left_reg;
            endcase
        end
    end

    // Output size clamped to the store
    logic [tcsa_pkg::SIZE_W-1:0] lim_h, lim_w;
    assign lim_h = (out_height_reg > tcsa_pkg::SIZE_W'(tcsa_pkg::SIZE_MAX))
                 ? tcsa_pkg::SIZE_W'(tcsa_pkg::SIZE_MAX) : out_height_reg;
    assign lim_w = (out_width_reg > tcsa_pkg::SIZE_W'(tcsa_pkg::SIZE_MAX))
                 ? tcsa_pkg::SIZE_W'(tcsa_pkg::SIZE_MAX) : out_width_reg;

    // Captured word
    logic signed [tcsa_pkg::VAL_W-1:0] val_reg;
    logic [tcsa_pkg::COORD_W-1:0]      row_reg, col_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg <= in_value;
            row_reg <= in_row;
            col_reg <= in_col;
        end
    end

    // Weight store, written on a load word that falls inside the kernel
    logic signed [tcsa_pkg::VAL_W-1:0] wt_reg [tcsa_pkg::W_DEPTH];
    logic                              wt_in_range;
    logic [tcsa_pkg::WIDX_W-1:0]       wt_waddr;

    assign wt_in_range = (tcsa_pkg::COORD_W'(in_row) < tcsa_pkg::COORD_W'(tcsa_pkg::KERNEL_H))
                      && (tcsa_pkg::COORD_W'(in_col) < tcsa_pkg::COORD_W'(tcsa_pkg::KERNEL_W));
    assign wt_waddr = tcsa_pkg::WIDX_W'(tcsa_pkg::WIDX_W'(in_row)
                    * tcsa_pkg::WIDX_W'(tcsa_pkg::KERNEL_W) + tcsa_pkg::WIDX_W'(in_col));

    always_ff @(posedge aclk) begin
        if (cmd.wt_wr && wt_in_range) begin
            wt_reg[wt_waddr] <= in_value;
        end
    end

    // Tap positions: base at load, then dilation steps per tap
    logic signed [tcsa_pkg::POS_W-1:0] base_row, base_col;
    logic signed [tcsa_pkg::POS_W-1:0] base_col_reg;
    logic signed [tcsa_pkg::POS_W-1:0] orow_reg, ocol_reg;

    assign base_row = $signed(tcsa_pkg::POS_W'(in_row) * tcsa_pkg::POS_W'(stride_rows_reg))
                    - $signed(tcsa_pkg::POS_W'(pad_top_reg));
    assign base_col = $signed(tcsa_pkg::POS_W'(in_col) * tcsa_pkg::POS_W'(stride_cols_reg))
                    - $signed(tcsa_pkg::POS_W'(pad_left_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_col_reg <= base_col;
            orow_reg     <= base_row;
            ocol_reg     <= base_col;
        end else if (cmd.tap_en) begin
            if (cmd.tap_wrap) begin
                ocol_reg <= base_col_reg;
                orow_reg <= orow_reg + $signed(tcsa_pkg::POS_W'(dilation_rows_reg));
            end else begin
                ocol_reg <= ocol_reg + $signed(tcsa_pkg::POS_W'(dilation_cols_reg));
            end
        end
    end

    // Tap stage: bounds check and address
    logic                        tap_in;
    logic [tcsa_pkg::ADDR_W-1:0] tap_addr;
    logic [tcsa_pkg::ADDR_W-1:0] item_addr;
    logic                        item_in;

    assign tap_in = !orow_reg[tcsa_pkg::POS_W-1] && !ocol_reg[tcsa_pkg::POS_W-1]
        && (orow_reg[tcsa_pkg::POS_W-2:0] < (tcsa_pkg::POS_W-1)'(lim_h))
        && (ocol_reg[tcsa_pkg::POS_W-2:0] < (tcsa_pkg::POS_W-1)'(lim_w));
    assign tap_addr = tcsa_pkg::ADDR_W'(tcsa_pkg::ADDR_W'(orow_reg[tcsa_pkg::POS_W-2:0])
                    * tcsa_pkg::ADDR_W'(tcsa_pkg::OUT_DIM)
                    + tcsa_pkg::ADDR_W'(ocol_reg[tcsa_pkg::POS_W-2:0]));
    assign item_addr = tcsa_pkg::ADDR_W'(tcsa_pkg::ADDR_W'(row_reg)
                     * tcsa_pkg::ADDR_W'(tcsa_pkg::OUT_DIM) + tcsa_pkg::ADDR_W'(col_reg));
    assign item_in = ({1'b0, row_reg} < lim_h) && ({1'b0, col_reg} < lim_w);

    // Accumulate stage registers
    logic                               s1_valid_reg;
    logic [tcsa_pkg::ADDR_W-1:0]        s1_addr_reg;
    logic signed [tcsa_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.tap_en && tap_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tap_en) begin
            s1_addr_reg <= tap_addr;
            prod_reg    <= val_reg * wt_reg[cmd.widx];
        end
    end

    // Accumulator memory, one write and one registered read port
    logic [tcsa_pkg::ACC_W-1:0] acc_mem [tcsa_pkg::ACC_DEPTH];
    logic [tcsa_pkg::ACC_W-1:0] rd_data_reg;
    logic                       mem_re;
    logic [tcsa_pkg::ADDR_W-1:0] mem_raddr;
    logic                       mem_we;
    logic [tcsa_pkg::ADDR_W-1:0] mem_waddr;
    logic [tcsa_pkg::ACC_W-1:0] mem_wdata;

    assign mem_re    = cmd.tap_en || cmd.rd_en;
    assign mem_raddr = cmd.rd_en ? item_addr : tap_addr;

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= acc_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            acc_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Back-to-back taps on one entry: take the value just written
    logic                        fwd_valid_reg;
    logic [tcsa_pkg::ADDR_W-1:0] fwd_addr_reg;
    logic [tcsa_pkg::ACC_W-1:0]  fwd_data_reg;

    logic signed [tcsa_pkg::ACC_W-1:0] acc_old;
    logic signed [tcsa_pkg::ACC_W:0]   acc_sum;
    logic signed [tcsa_pkg::ACC_W-1:0] acc_sat;

    assign acc_old = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
                   ? $signed(fwd_data_reg) : $signed(rd_data_reg);
    assign acc_sum = $signed({acc_old[tcsa_pkg::ACC_W-1], acc_old})
                   + $signed((tcsa_pkg::ACC_W+1)'(prod_reg));

    // Saturate to 40 bits
    always_comb begin
        if (acc_sum[tcsa_pkg::ACC_W] != acc_sum[tcsa_pkg::ACC_W-1]) begin
            acc_sat = acc_sum[tcsa_pkg::ACC_W] ? tcsa_pkg::ACC_MIN : tcsa_pkg::ACC_MAX;
        end else begin
            acc_sat = acc_sum[tcsa_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= acc_sat;
        end
    end

    // Write port: bias sweep or tap result
    logic signed [tcsa_pkg::ACC_W-1:0] bias;
    assign bias = $signed(tcsa_pkg::ACC_W'(val_reg)) <<< tcsa_pkg::FRAC_SH;

    always_comb begin
        mem_we    = cmd.clr_en || s1_valid_reg;
        mem_waddr = cmd.clr_en ? cmd.clr_addr : s1_addr_reg;
        mem_wdata = cmd.clr_en ? bias : acc_sat;
    end

    // Output register
    logic                              out_valid_reg;
    logic signed [tcsa_pkg::ACC_W-1:0] out_data_reg;

    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= item_in ? $signed(rd_data_reg) : '0;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_value = out_data_reg;

`ifndef SYNTHESIS
    // the bias sweep never shares the write port with a tap result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_en && s1_valid_reg))
        else $error("write port conflict between clear and accumulate");

    // a new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while stalled");

    // a tap result is written the cycle after its tap was issued
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $past(cmd.tap_en))
        else $error("accumulate without a tap");

    // read port is driven by one source at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.tap_en && cmd.rd_en))
        else $error("read port conflict between tap and read word");
`endif

endmodule

// ===== hdl/transposed_conv2d_scatter_accumulate.sv =====
// Channel  | Dir | Ports                         | Contents
// s_ input | in  | s_tvalid s_tready s_tdata/user | word: clear, load, scatter or read
// m_ out   | out | m_tvalid m_tready m_tdata      | accumulator returned by a read word
// cfg      | in  | cfg_wr_en cfg_index cfg_data   | size, stride, dilation, pad registers
//
// A clear sweeps every entry, one entry per cycle; a scatter issues every kernel tap and
// then drains; one word in work at a time.
// Taps issue one per cycle on the memory's read and write ports; a tap that hits the
// entry written by the tap just before takes the forwarded sum.
// Reset (aresetn, synchronous, active low) loads register defaults and idles control.
// While m_tready is low a result waits in the output register; a second read stalls.
module transposed_conv2d_scatter_accumulate (
    input  logic        aclk,
    input  logic        aresetn,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[15:0], row[21:16], col[27:22], zero[31:28]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[39:0]
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    tcsa_pkg::tcsa_cmd_t    cmd;
    tcsa_pkg::tcsa_status_t status;

    logic signed [tcsa_pkg::ACC_W-1:0] out_value;

    tcsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op_in    (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcsa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_value  ($signed(s_tdata[15:0])),
        .in_row    (s_tdata[21:16]),
        .in_col    (s_tdata[27:22]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_value (out_value),
        .cmd       (cmd),
        .status    (status)
    );

    assign m_tdata = out_value;

endmodule
